/* hdl/cpp_pkg.sv */
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants of the camera perspective projector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FOCAL     = 3'd0;
    localparam logic [2:0] CFG_CAM_X     = 3'd1;
    localparam logic [2:0] CFG_CAM_Y     = 3'd2;
    localparam logic [2:0] CFG_CAM_Z     = 3'd3;
    localparam logic [2:0] CFG_COS_YAW   = 3'd4;
    localparam logic [2:0] CFG_SIN_YAW   = 3'd5;
    localparam logic [2:0] CFG_COS_PITCH = 3'd6;
    localparam logic [2:0] CFG_SIN_PITCH = 3'd7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Divider geometry: quotient bits kept, numerator and divisor widths.
    localparam int QUOT_W = 17;
    localparam int NUM_W  = 63;
    localparam int DEN_W  = 50;
    localparam int REM_W  = DEN_W + QUOT_W;

    typedef struct packed {
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic signed [23:0] vertex_z;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               behind_eye;
        logic               clipped;
    } t_out_beat;

    // Flags that ride alongside the division.
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic behind;
    } t_div_side;

    // One coordinate's division result.
    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic              ovf;
        logic              rem_nz;
    } t_div_res;

endpackage

`default_nettype wire

/* hdl/cpp_divider.sv */
// ----------------------------------------------------------------------------
// cpp_divider
// Pipelined restoring divider, two numerators over one divisor, one
// quotient bit per stage with an overflow test up front.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpp_divider import cpp_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_vld,
    input  wire t_div_side         i_side,
    input  wire logic [NUM_W-1:0]  i_num_x,
    input  wire logic [NUM_W-1:0]  i_num_y,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_vld,
    output t_div_side              o_side,
    output t_div_res               o_res_x,
    output t_div_res               o_res_y
);

    logic              r_vld  [0:QUOT_W];
    t_div_side         r_side [0:QUOT_W];
    logic [REM_W-1:0]  r_rem_x[0:QUOT_W];
    logic [REM_W-1:0]  r_rem_y[0:QUOT_W];
    logic [QUOT_W-1:0] r_q_x  [0:QUOT_W];
    logic [QUOT_W-1:0] r_q_y  [0:QUOT_W];
    logic              r_ovf_x[0:QUOT_W];
    logic              r_ovf_y[0:QUOT_W];
    logic [REM_W-1:0]  r_dsh  [0:QUOT_W];

    logic [REM_W-1:0]  n_rem_x[1:QUOT_W];
    logic [REM_W-1:0]  n_rem_y[1:QUOT_W];
    logic              n_ge_x [1:QUOT_W];
    logic              n_ge_y [1:QUOT_W];
    logic [REM_W-1:0]  w_den_top;
    logic [REM_W-1:0]  w_num_x;
    logic [REM_W-1:0]  w_num_y;

    assign w_den_top = {i_den, {QUOT_W{1'b0}}};
    assign w_num_x   = {{(REM_W-NUM_W){1'b0}}, i_num_x};
    assign w_num_y   = {{(REM_W-NUM_W){1'b0}}, i_num_y};

    // Stage j tests the divisor shifted left by QUOT_W-j.
    always_comb begin
        for (int j = 1; j <= QUOT_W; j++) begin
            n_ge_x[j]  = r_rem_x[j-1] >= (r_dsh[j-1] >> j);
            n_ge_y[j]  = r_rem_y[j-1] >= (r_dsh[j-1] >> j);
            n_rem_x[j] = n_ge_x[j] ? r_rem_x[j-1] - (r_dsh[j-1] >> j) : r_rem_x[j-1];
            n_rem_y[j] = n_ge_y[j] ? r_rem_y[j-1] - (r_dsh[j-1] >> j) : r_rem_y[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QUOT_W; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 1; j <= QUOT_W; j++) begin
                r_vld[j] <= r_vld[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0]  <= i_side;
            r_dsh[0]   <= w_den_top;
            r_rem_x[0] <= w_num_x;
            r_rem_y[0] <= w_num_y;
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_ovf_x[0] <= w_num_x >= w_den_top;
            r_ovf_y[0] <= w_num_y >= w_den_top;
            for (int j = 1; j <= QUOT_W; j++) begin
                r_side[j]  <= r_side[j-1];
                r_dsh[j]   <= r_dsh[j-1];
                r_ovf_x[j] <= r_ovf_x[j-1];
                r_ovf_y[j] <= r_ovf_y[j-1];
                r_rem_x[j] <= n_rem_x[j];
                r_rem_y[j] <= n_rem_y[j];
                r_q_x[j]   <= {r_q_x[j-1][QUOT_W-2:0], n_ge_x[j]};
                r_q_y[j]   <= {r_q_y[j-1][QUOT_W-2:0], n_ge_y[j]};
            end
        end
    end

    assign o_vld          = r_vld[QUOT_W];
    assign o_side         = r_side[QUOT_W];
    assign o_res_x.quot   = r_q_x[QUOT_W];
    assign o_res_x.ovf    = r_ovf_x[QUOT_W];
    assign o_res_x.rem_nz = r_rem_x[QUOT_W] != '0;
    assign o_res_y.quot   = r_q_y[QUOT_W];
    assign o_res_y.ovf    = r_ovf_y[QUOT_W];
    assign o_res_y.rem_nz = r_rem_y[QUOT_W] != '0;

endmodule

`default_nettype wire

/* hdl/camera_perspective_projector_core.sv */
// ----------------------------------------------------------------------------
// camera_perspective_projector_core
// Camera transform and perspective projection of Q15.8 vertices to screen.
// ----------------------------------------------------------------------------
// The core takes one vertex beat per clock while the output is not stalled
// and returns one screen beat per vertex, in order. The path runs through
// the nine transform stages (camera offset, yaw products and sums, pitch
// products, sums and rounding, depth, and the split numerator multiply)
// followed by the 18-stage divider, one quotient bit a stage, and the
// output register. The whole pipeline advances together: it moves whenever
// the output register is empty or is being taken, so a stalled output
// holds every stage and nothing is lost.
// Configuration writes land at once and must only be made while the core
// holds no vertex in flight.
`timescale 1ns / 1ps
`default_nettype none

module camera_perspective_projector_core import cpp_pkg::*; #(
    parameter int unsigned CENTER_X = 640,
    parameter int unsigned CENTER_Y = 360
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_beat              i_in_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_beat                  o_out_data
);

    // Configuration registers.
    logic        [22:0] r_focal;
    logic signed [23:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [15:0] r_cos_yaw, r_sin_yaw, r_cos_pitch, r_sin_pitch;
    logic signed [15:0] n_trig;
    logic signed [15:0] w_trig_raw;

    assign w_trig_raw = $signed(i_cfg_data[15:0]);

    // Trig values beyond unity are clamped when written.
    always_comb begin
        if (w_trig_raw > 16'sd16384) begin
            n_trig = 16'sd16384;
        end else if (w_trig_raw < -16'sd16384) begin
            n_trig = -16'sd16384;
        end else begin
            n_trig = w_trig_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal     <= 23'd128000;
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_yaw   <= '0;
            r_cos_pitch <= 16'sd16384;
            r_sin_pitch <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCAL:     r_focal     <= i_cfg_data[22:0];
                CFG_CAM_X:     r_cam_x     <= $signed(i_cfg_data);
                CFG_CAM_Y:     r_cam_y     <= $signed(i_cfg_data);
                CFG_CAM_Z:     r_cam_z     <= $signed(i_cfg_data);
                CFG_COS_YAW:   r_cos_yaw   <= n_trig;
                CFG_SIN_YAW:   r_sin_yaw   <= n_trig;
                CFG_COS_PITCH: r_cos_pitch <= n_trig;
                CFG_SIN_PITCH: r_sin_pitch <= n_trig;
                default: ;
            endcase
        end
    end

    // Global advance: the output register is empty or being drained.
    logic r_out_vld;
    logic w_en;
    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    localparam int NSTG = 9;
    logic r_vld[1:NSTG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[1] <= i_in_valid;
            for (int s = 2; s <= NSTG; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Stage 1: offset from the camera.
    logic signed [24:0] r1_dx, r1_dy, r1_dz;
    // Stage 2: yaw products.
    logic signed [40:0] r2_xc, r2_zs, r2_xs, r2_zc;
    logic signed [24:0] r2_dy;
    // Stage 3: yaw sums.
    logic signed [41:0] r3_xr, r3_zr;
    logic signed [24:0] r3_dy;
    // Stage 4: pitch products.
    logic signed [40:0] r4_yc, r4_ys;
    logic signed [57:0] r4_zs, r4_zc;
    logic signed [41:0] r4_xr;
    // Stage 5: pitch sums, still scaled by 2^14.
    logic signed [58:0] r5_ty, r5_td;
    logic signed [41:0] r5_xr;
    // Stage 6: pitch sums divided by 2^14 toward zero.
    logic signed [44:0] r6_yr, r6_dep;
    logic signed [41:0] r6_xr;
    // Stage 7: denominator, magnitudes and signs.
    logic signed [45:0] r7_den;
    logic        [40:0] r7_mx, r7_my;
    logic               r7_nx, r7_ny;
    // Stage 8: numerator partial products.
    logic        [43:0] r8_lx, r8_ly;
    logic        [42:0] r8_hx, r8_hy;
    logic        [DEN_W-1:0] r8_div;
    logic               r8_nx, r8_ny, r8_beh;
    // Stage 9: full numerator magnitudes.
    logic        [NUM_W-1:0] r9_nmx, r9_nmy;
    logic        [DEN_W-1:0] r9_div;
    t_div_side          r9_side;

    logic signed [58:0] w_ty_r, w_td_r;
    logic signed [41:0] w_ax, w_ay;
    logic signed [45:0] w_den;
    logic        [63:0] w_nx, w_ny;

    assign w_ty_r = r5_ty + (r5_ty[58] ? 59'sd16383 : 59'sd0);
    assign w_td_r = r5_td + (r5_td[58] ? 59'sd16383 : 59'sd0);
    assign w_den  = 46'(r6_dep) + $signed({9'd0, r_focal, 14'd0});
    assign w_ax   = r6_xr[41] ? -r6_xr : r6_xr;
    assign w_ay   = r6_yr[44] ? -42'(r6_yr) : 42'(r6_yr);
    assign w_nx   = 64'(r8_lx) + {r8_hx, 21'd0};
    assign w_ny   = 64'(r8_ly) + {r8_hy, 21'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx <= 25'(i_in_data.vertex_x) - 25'(r_cam_x);
            r1_dy <= 25'(i_in_data.vertex_y) - 25'(r_cam_y);
            r1_dz <= 25'(i_in_data.vertex_z) - 25'(r_cam_z);

            r2_xc <= r1_dx * r_cos_yaw;
            r2_zs <= r1_dz * r_sin_yaw;
            r2_xs <= r1_dx * r_sin_yaw;
            r2_zc <= r1_dz * r_cos_yaw;
            r2_dy <= r1_dy;

            r3_xr <= 42'(r2_xc) - 42'(r2_zs);
            r3_zr <= 42'(r2_xs) + 42'(r2_zc);
            r3_dy <= r2_dy;

            r4_yc <= r3_dy * r_cos_pitch;
            r4_ys <= r3_dy * r_sin_pitch;
            r4_zs <= r3_zr * r_sin_pitch;
            r4_zc <= r3_zr * r_cos_pitch;
            r4_xr <= r3_xr;

            r5_ty <= $signed({r4_yc[40], r4_yc, 14'd0}) - 59'(r4_zs);
            r5_td <= $signed({r4_ys[40], r4_ys, 14'd0}) + 59'(r4_zc);
            r5_xr <= r4_xr;

            r6_yr  <= w_ty_r[58:14];
            r6_dep <= w_td_r[58:14];
            r6_xr  <= r5_xr;

            r7_den <= w_den;
            r7_mx  <= w_ax[40:0];
            r7_my  <= w_ay[40:0];
            r7_nx  <= r6_xr[41];
            r7_ny  <= r6_yr[44];

            r8_lx  <= r7_mx[20:0] * r_focal;
            r8_hx  <= r7_mx[40:21] * r_focal;
            r8_ly  <= r7_my[20:0] * r_focal;
            r8_hy  <= r7_my[40:21] * r_focal;
            r8_div <= {r7_den[41:0], 8'd0};
            r8_nx  <= r7_nx;
            r8_ny  <= r7_ny;
            r8_beh <= (r7_den[45] || r7_den == '0);

            r9_nmx         <= w_nx[NUM_W-1:0];
            r9_nmy         <= w_ny[NUM_W-1:0];
            // A behind-eye vertex gets a unit divisor to keep the divider sane.
            r9_div         <= r8_beh ? DEN_W'(1) : r8_div;
            r9_side.neg_x  <= r8_nx;
            r9_side.neg_y  <= r8_ny;
            r9_side.behind <= r8_beh;
        end
    end

    logic      w_dv_vld;
    t_div_side w_dv_side;
    t_div_res  w_res_x, w_res_y;

    cpp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vld[NSTG]),
        .i_side  (r9_side),
        .i_num_x (r9_nmx),
        .i_num_y (r9_nmy),
        .i_den   (r9_div),
        .o_vld   (w_dv_vld),
        .o_side  (w_dv_side),
        .o_res_x (w_res_x),
        .o_res_y (w_res_y)
    );

    // Place a quotient about the center, truncate the sum toward zero and
    // saturate to 16 bits.
    logic signed [15:0] n_sx, n_sy;
    logic               n_clip_x, n_clip_y;

    always_comb begin
        logic signed [19:0] qx, qy, sx, sy;
        qx = w_dv_side.neg_x ? -20'(w_res_x.quot) : 20'(w_res_x.quot);
        qy = w_dv_side.neg_y ? -20'(w_res_y.quot) : 20'(w_res_y.quot);
        sx = 20'(CENTER_X) + qx;
        sy = 20'(CENTER_Y) + qy;
        if (w_res_x.rem_nz && !w_dv_side.neg_x && sx < 0) begin
            sx = sx + 20'sd1;
        end else if (w_res_x.rem_nz && w_dv_side.neg_x && sx > 0) begin
            sx = sx - 20'sd1;
        end
        if (w_res_y.rem_nz && !w_dv_side.neg_y && sy < 0) begin
            sy = sy + 20'sd1;
        end else if (w_res_y.rem_nz && w_dv_side.neg_y && sy > 0) begin
            sy = sy - 20'sd1;
        end
        n_clip_x = 1'b1;
        if (w_res_x.ovf) begin
            n_sx = w_dv_side.neg_x ? -16'sd32768 : 16'sd32767;
        end else if (sx > 20'sd32767) begin
            n_sx = 16'sd32767;
        end else if (sx < -20'sd32768) begin
            n_sx = -16'sd32768;
        end else begin
            n_sx     = sx[15:0];
            n_clip_x = 1'b0;
        end
        n_clip_y = 1'b1;
        if (w_res_y.ovf) begin
            n_sy = w_dv_side.neg_y ? -16'sd32768 : 16'sd32767;
        end else if (sy > 20'sd32767) begin
            n_sy = 16'sd32767;
        end else if (sy < -20'sd32768) begin
            n_sy = -16'sd32768;
        end else begin
            n_sy     = sy[15:0];
            n_clip_y = 1'b0;
        end
    end

    t_out_beat r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_dv_side.behind) begin
                r_out.screen_x   <= 16'(CENTER_X);
                r_out.screen_y   <= 16'(CENTER_Y);
                r_out.behind_eye <= 1'b1;
                r_out.clipped    <= 1'b0;
            end else begin
                r_out.screen_x   <= n_sx;
                r_out.screen_y   <= n_sy;
                r_out.behind_eye <= 1'b0;
                r_out.clipped    <= n_clip_x || n_clip_y;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // A behind-eye beat always sits at the center and is never clipped.
    a_behind_center: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.behind_eye) |->
        (!o_out_data.clipped && o_out_data.screen_x == 16'(CENTER_X)
         && o_out_data.screen_y == 16'(CENTER_Y)))
        else $error("behind-eye beat not at center");

    // A clipped beat has at least one coordinate on a bound.
    a_clip_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.clipped) |->
        (o_out_data.screen_x == 16'sh7fff || o_out_data.screen_x == 16'sh8000
         || o_out_data.screen_y == 16'sh7fff || o_out_data.screen_y == 16'sh8000))
        else $error("clipped beat not saturated");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
